[src/tlbl_pkg.sv]
// Translation buffer package: request kind codes, fixed field widths, the
// cell row control struct and the broadcast write strobe. No dependencies.
package tlbl_pkg;

    localparam int KIND_W      = 2;
    localparam int STAMP_W     = 32;
    localparam int OUT_FRAME_W = 20;
    localparam int SLOT_W      = 4;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_LOOKUP = 2'd0;
    localparam t_kind KIND_INSERT = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;

    // control part of the wavefront that travels from cell to cell
    typedef struct packed {
        logic live;
        logic found;
        logic min_valid;
    } t_ctl;

    // write strobe broadcast to all cells
    typedef struct packed {
        logic en;
        logic fill;
    } t_wr;

endpackage

[src/tlbl_ifs.sv]
// Handshake interfaces for the translation buffer request and result channels.
// Depends on tlbl_pkg.
interface tlbl_req_if import tlbl_pkg::*; #(
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
);
    logic                  valid;
    logic                  ready;
    t_kind                 kind;
    logic [PAGE_BITS-1:0]  page_number;
    logic [FRAME_BITS-1:0] frame_number;
    logic [STAMP_W-1:0]    stamp;

    modport source (output valid, kind, page_number, frame_number, stamp, input ready);
    modport sink   (input valid, kind, page_number, frame_number, stamp, output ready);
endinterface

interface tlbl_rsp_if import tlbl_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [OUT_FRAME_W-1:0] hit_frame;
    logic [SLOT_W-1:0]      slot_used;

    modport source (output valid, hit, hit_frame, slot_used, input ready);
    modport sink   (input valid, hit, hit_frame, slot_used, output ready);
endinterface

[src/tlb_lru_lookup_insert_top.sv]
// Fully associative translation buffer with least-recently-used replacement.
// Depends on tlbl_pkg, tlbl_ifs and tlbl_cell.
// Each request is handled one at a time: it travels once along the row of
// ENTRIES cells, one cell per cycle, picking up the first matching page and the
// oldest stamp; then, for an insert or a lookup hit, the entry is written, and
// the result is registered. A new request is taken only after the last one has
// finished. A finished result may wait on the output while the next request is
// already in the row; that request then holds at the end of the row until the
// waiting result is taken.
module tlb_lru_lookup_insert_top import tlbl_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlbl_req_if.sink   i_req,
    tlbl_rsp_if.source o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PARK = 2'd2;

    logic [1:0]            r_state;
    logic                  r_inject;
    logic [CNT_W-1:0]      r_fill;
    t_kind                 r_kind;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic [STAMP_W-1:0]    r_stamp;
    logic                  r_t_found;
    logic [IDX_W-1:0]      r_t_hit_idx;
    logic [FRAME_BITS-1:0] r_t_hit_frame;
    logic [IDX_W-1:0]      r_t_min_idx;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [OUT_FRAME_W-1:0] r_out_frame;
    logic [SLOT_W-1:0]     r_out_slot;

    t_ctl                  w_ctl       [ENTRIES+1];
    logic [IDX_W-1:0]      w_hit_idx   [ENTRIES+1];
    logic [FRAME_BITS-1:0] w_hit_frame [ENTRIES+1];
    logic [STAMP_W-1:0]    w_min_stamp [ENTRIES+1];
    logic [IDX_W-1:0]      w_min_idx   [ENTRIES+1];
    logic [ENTRIES:0]      w_live;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_hit;
    t_wr                   w_wr;
    logic [IDX_W-1:0]      w_wr_idx;
    logic [IDX_W+SLOT_W-1:0] w_slot_ext;
    logic [FRAME_BITS+OUT_FRAME_W-1:0] w_frame_ext;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_finish   = (r_state == ST_PARK) && w_out_free;
    assign i_req.ready = (r_state == ST_IDLE);

    assign w_ctl[0]       = '{live: r_inject, found: 1'b0, min_valid: 1'b0};
    assign w_hit_idx[0]   = '0;
    assign w_hit_frame[0] = '0;
    assign w_min_stamp[0] = '0;
    assign w_min_idx[0]   = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tlbl_cell #(
            .CELL_IDX   (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .PAGE_BITS  (PAGE_BITS),
            .FRAME_BITS (FRAME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_kind      (r_kind),
            .i_page      (r_page),
            .i_frame     (r_frame),
            .i_stamp     (r_stamp),
            .i_fill      (r_fill),
            .i_wr        (w_wr),
            .i_wr_idx    (w_wr_idx),
            .i_ctl       (w_ctl[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_frame (w_hit_frame[g]),
            .i_min_stamp (w_min_stamp[g]),
            .i_min_idx   (w_min_idx[g]),
            .o_ctl       (w_ctl[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_frame (w_hit_frame[g+1]),
            .o_min_stamp (w_min_stamp[g+1]),
            .o_min_idx   (w_min_idx[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= ENTRIES; k++) begin
            w_live[k] = w_ctl[k].live;
        end
    end

    always_comb begin
        w_hit    = (r_kind == KIND_LOOKUP) && r_t_found;
        w_wr     = '0;
        w_wr_idx = r_t_hit_idx;
        case (r_kind)
            KIND_LOOKUP: begin
                w_wr.en = w_finish && r_t_found;
            end
            KIND_INSERT: begin
                w_wr.en   = w_finish;
                w_wr.fill = 1'b1;
                w_wr_idx  = (r_fill < FULL) ? r_fill[IDX_W-1:0] : r_t_min_idx;
            end
            default: begin
                w_wr = '0;
            end
        endcase
        w_slot_ext  = {{SLOT_W{1'b0}}, w_wr_idx};
        w_frame_ext = {{OUT_FRAME_W{1'b0}}, r_t_hit_frame};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inject    <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject <= w_accept;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_ctl[ENTRIES].live) begin
                        r_state <= ST_PARK;
                    end
                end
                ST_PARK: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (r_kind == KIND_CLEAR) begin
                            r_fill <= '0;
                        end else if ((r_kind == KIND_INSERT) && (r_fill < FULL)) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_req.kind;
            r_page  <= i_req.page_number;
            r_frame <= i_req.frame_number;
            r_stamp <= i_req.stamp;
        end
        if (w_ctl[ENTRIES].live) begin
            r_t_found     <= w_ctl[ENTRIES].found;
            r_t_hit_idx   <= w_hit_idx[ENTRIES];
            r_t_hit_frame <= w_hit_frame[ENTRIES];
            r_t_min_idx   <= w_min_idx[ENTRIES];
        end
        if (w_finish) begin
            r_out_hit   <= w_hit;
            r_out_frame <= w_hit ? w_frame_ext[OUT_FRAME_W-1:0] : '0;
            r_out_slot  <= (w_hit || (r_kind == KIND_INSERT)) ? w_slot_ext[SLOT_W-1:0] : '0;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.hit_frame = r_out_frame;
    assign o_rsp.slot_used = r_out_slot;

    a_one_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_live) <= 1)
        else $error("more than one request in the cell row");

    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[ENTRIES].live |-> (r_state == ST_RUN))
        else $error("request left the cell row outside the run state");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_live == '0))
        else $error("cell row busy while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count beyond capacity");

    a_out_after_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_PARK))
        else $error("result raised without a finished request");

endmodule

[src/tlbl_cell.sv]
// One translation buffer entry with its compare and oldest-stamp stage.
// Depends on tlbl_pkg; instantiated in a row by tlb_lru_lookup_insert_top.
module tlbl_cell import tlbl_pkg::*; #(
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_kind                 i_kind,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic [STAMP_W-1:0]    i_stamp,
    input  logic [CNT_W-1:0]      i_fill,
    input  t_wr                   i_wr,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  t_ctl                  i_ctl,
    input  logic [IDX_W-1:0]      i_hit_idx,
    input  logic [FRAME_BITS-1:0] i_hit_frame,
    input  logic [STAMP_W-1:0]    i_min_stamp,
    input  logic [IDX_W-1:0]      i_min_idx,
    output t_ctl                  o_ctl,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [FRAME_BITS-1:0] o_hit_frame,
    output logic [STAMP_W-1:0]    o_min_stamp,
    output logic [IDX_W-1:0]      o_min_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic [STAMP_W-1:0]    r_stamp;
    t_ctl                  r_ctl;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [FRAME_BITS-1:0] r_hit_frame;
    logic [STAMP_W-1:0]    r_min_stamp;
    logic [IDX_W-1:0]      r_min_idx;

    logic w_valid;
    logic w_match;
    logic w_older;

    assign w_valid = MY_CNT < i_fill;
    assign w_match = (i_kind == KIND_LOOKUP) && w_valid && !i_ctl.found && (r_page == i_page);
    assign w_older = w_valid && (!i_ctl.min_valid || (r_stamp < i_min_stamp));

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            r_stamp <= i_stamp;
            if (i_wr.fill) begin
                r_page  <= i_page;
                r_frame <= i_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.live      <= i_ctl.live;
            r_ctl.found     <= i_ctl.found | w_match;
            r_ctl.min_valid <= i_ctl.min_valid | w_older;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx   <= w_match ? MY_IDX : i_hit_idx;
        r_hit_frame <= w_match ? r_frame : i_hit_frame;
        r_min_stamp <= w_older ? r_stamp : i_min_stamp;
        r_min_idx   <= w_older ? MY_IDX : i_min_idx;
    end

    assign o_ctl       = r_ctl;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_frame = r_hit_frame;
    assign o_min_stamp = r_min_stamp;
    assign o_min_idx   = r_min_idx;

endmodule
